// File: hdl/dqa_pkg.sv
// Package: shared types and constants for the dual quaternion accumulator.
package dqa_pkg;
    localparam int CompWidthDefault = 32;
    localparam int FracBitsDefault  = 16;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_DMUL = 2'd1,
        MODE_RMUL = 2'd2,
        MODE_NORM = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MULWB,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_DOT,
        ST_PROJ,
        ST_NORMWB,
        ST_OUT
    } state_t;
endpackage

// File: hdl/dqa_if.sv
// Interface: valid/ready request channel with a generic payload.
interface dqa_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/dual_quaternion_accumulator.sv
// Top level: dual quaternion accumulator with one shared multiplier and divider.
//
//  channel | dir | payload
//  req     | in  | mode, in_real_w..z, in_dual_w..z
//  rsp     | out | out_real_w..z, out_dual_w..z, zero_norm
//
// Load goes from accept straight to response. Both multiply modes run accept, 48 products
// through one multiplier (three groups of 16), write-back, response.
// Normalize runs 4 square steps, CW+1 root steps, 8 divisions of CW+FB quotient bits
// each on a one-bit restoring divider, 4 dot and 4 projection products, write-back and
// response; on zero length it goes from the root steps straight to the response.
// Reset loads the identity. The block takes no request while one is in flight or a
// response waits.
module dual_quaternion_accumulator #(
    parameter int CW = dqa_pkg::CompWidthDefault,
    parameter int FB = dqa_pkg::FracBitsDefault
) (
    input  logic clk,
    input  logic rst_n,
    dqa_if.sink   req,
    dqa_if.source rsp
);
    import dqa_pkg::*;

    localparam int PW  = 2 * CW;
    localparam int DW  = CW + FB;     // dividend width
    localparam int SQW = 2 * CW + 2;  // sum of squares width
    localparam int RTW = CW + 1;      // root width
    localparam logic signed [PW+3:0] SMAX = ((PW + 4)'(1) <<< (CW - 1)) - (PW + 4)'(1);
    localparam logic signed [PW+3:0] SMIN = -((PW + 4)'(1) <<< (CW - 1));
    localparam logic [SQW-1:0] SQMAX = (SQW'(1) << PW) - SQW'(1);

    typedef logic signed [CW-1:0] comp_t;

    state_t st_reg, st_next;
    comp_t  ar_reg [4];
    comp_t  ad_reg [4];
    comp_t  or_reg [4];
    comp_t  od_reg [4];
    comp_t  nr_reg [4];
    comp_t  nd_reg [4];
    mode_t  mode_reg;
    logic   zn_reg;
    logic [5:0] cnt_reg;
    logic [$clog2(DW+1)-1:0] bit_reg;
    logic signed [PW+3:0] sum_reg [4];
    logic signed [PW+3:0] dsum_reg [4];
    logic [SQW-1:0] sq_reg;
    logic [SQW-1:0] rem_reg;
    logic [RTW-1:0] root_reg;
    logic [RTW-1:0] div_reg;
    logic [DW-1:0]  quo_reg;
    logic [RTW:0]   drem_reg;
    logic           neg_reg;
    comp_t          d_reg;

    // Shared multiplier: selected operands per step
    comp_t ma, mb;
    logic signed [PW-1:0] prod;
    logic signed [PW-FB-1:0] prod_sh;
    logic [1:0] ti, ai, bi;
    logic sub;
    logic [1:0] grp;

    // product schedule: cnt[5:4] group, [3:2] term, [1:0] output component
    always_comb
    begin
        logic [1:0] k, o;
        k   = cnt_reg[3:2];
        o   = cnt_reg[1:0];
        grp = cnt_reg[5:4];
        ai  = k;
        ti  = o;
        bi  = k ^ o;
        case ({o, k})
            4'b0001, 4'b0010, 4'b0011, 4'b0111,
            4'b1001, 4'b1110:  sub = 1'b1;
            default:           sub = 1'b0;
        endcase
        ma = ar_reg[ai];
        mb = or_reg[bi];
        case (st_reg)
            ST_MUL:
            begin
                case (grp)
                    2'd0:    begin ma = ar_reg[ai]; mb = or_reg[bi]; end
                    2'd1:    begin ma = ad_reg[ai]; mb = or_reg[bi]; end
                    default: begin ma = ar_reg[ai]; mb = od_reg[bi]; end
                endcase
            end
            ST_SQ:   begin ma = ar_reg[cnt_reg[1:0]]; mb = ar_reg[cnt_reg[1:0]]; end
            ST_DOT:  begin ma = nr_reg[cnt_reg[1:0]]; mb = nd_reg[cnt_reg[1:0]]; end
            ST_PROJ: begin ma = nr_reg[cnt_reg[1:0]]; mb = d_reg; end
            default: ;
        endcase
    end

    assign prod    = PW'(ma) * PW'(mb);
    assign prod_sh = prod[PW-1:FB];

    function automatic comp_t sat(input logic signed [PW+3:0] v);
        if (v > SMAX) return SMAX[CW-1:0];
        if (v < SMIN) return SMIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    // running sum of squares
    logic [SQW-1:0] sq_sum;
    assign sq_sum = sq_reg + SQW'(unsigned'(prod));

    // root step values
    logic [SQW-1:0] rtrial;
    assign rtrial = (SQW'(root_reg) << (bit_reg + 1)) | (SQW'(1) << (2 * bit_reg));

    // divider: dividend is |c| << FB, one bit per cycle
    comp_t dsrc;
    logic [CW-1:0] dmag;
    logic [DW-1:0] dvd;
    logic [RTW:0]  dshift;
    logic signed [PW+3:0] qsig;
    assign dsrc   = cnt_reg[2] ? ad_reg[cnt_reg[1:0]] : ar_reg[cnt_reg[1:0]];
    assign dmag   = dsrc[CW-1] ? CW'(-dsrc) : dsrc;
    assign dvd    = {dmag, FB'(0)};
    assign dshift = {drem_reg[RTW-1:0], dvd[bit_reg - 1'b1]};
    assign qsig   = neg_reg ? -(PW + 4)'(quo_reg) : (PW + 4)'(quo_reg);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (req.valid)
                begin
                    case (mode_t'(req.data.mode))
                        MODE_LOAD: st_next = ST_OUT;
                        MODE_NORM: st_next = ST_SQ;
                        default:   st_next = ST_MUL;
                    endcase
                end
            ST_MUL:    if (cnt_reg == 6'd47) st_next = ST_MULWB;
            ST_MULWB:  st_next = ST_OUT;
            ST_SQ:     if (cnt_reg[1:0] == 2'd3) st_next = ST_SQRT;
            ST_SQRT:
                if (bit_reg == '0)
                    st_next = (root_reg == '0 && rem_reg < SQW'(1)) ? ST_OUT : ST_DIV;
            ST_DIV:    if (bit_reg == '0 && cnt_reg[2:0] == 3'd7) st_next = ST_DOT;
            ST_DOT:    if (cnt_reg[1:0] == 2'd3) st_next = ST_PROJ;
            ST_PROJ:   if (cnt_reg[1:0] == 2'd3) st_next = ST_NORMWB;
            ST_NORMWB: st_next = ST_OUT;
            ST_OUT:    if (rsp.ready) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    assign req.ready = (st_reg == ST_IDLE);
    assign rsp.valid = (st_reg == ST_OUT);
    always_comb
    begin
        rsp.data.out_real_w = ar_reg[0];
        rsp.data.out_real_x = ar_reg[1];
        rsp.data.out_real_y = ar_reg[2];
        rsp.data.out_real_z = ar_reg[3];
        rsp.data.out_dual_w = ad_reg[0];
        rsp.data.out_dual_x = ad_reg[1];
        rsp.data.out_dual_y = ad_reg[2];
        rsp.data.out_dual_z = ad_reg[3];
        rsp.data.zero_norm  = zn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
            bit_reg <= '0;
            zn_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                ar_reg[i] <= (i == 0) ? CW'(2 ** FB) : '0;
                ad_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                ST_IDLE:
                    if (req.valid)
                    begin
                        mode_reg  <= mode_t'(req.data.mode);
                        zn_reg    <= 1'b0;
                        or_reg[0] <= req.data.in_real_w;
                        or_reg[1] <= req.data.in_real_x;
                        or_reg[2] <= req.data.in_real_y;
                        or_reg[3] <= req.data.in_real_z;
                        od_reg[0] <= req.data.in_dual_w;
                        od_reg[1] <= req.data.in_dual_x;
                        od_reg[2] <= req.data.in_dual_y;
                        od_reg[3] <= req.data.in_dual_z;
                        cnt_reg   <= '0;
                        sq_reg    <= '0;
                        for (int i = 0; i < 4; i++) sum_reg[i] <= '0;
                        if (mode_t'(req.data.mode) == MODE_LOAD)
                        begin
                            ar_reg[0] <= req.data.in_real_w;
                            ar_reg[1] <= req.data.in_real_x;
                            ar_reg[2] <= req.data.in_real_y;
                            ar_reg[3] <= req.data.in_real_z;
                            ad_reg[0] <= req.data.in_dual_w;
                            ad_reg[1] <= req.data.in_dual_x;
                            ad_reg[2] <= req.data.in_dual_y;
                            ad_reg[3] <= req.data.in_dual_z;
                        end
                    end
                ST_MUL:
                begin
                    // group 2 lands on the dual sums too, skip it for mode 2
                    if (!(grp == 2'd2 && mode_reg == MODE_RMUL))
                    begin
                        if (grp == 2'd0)
                            sum_reg[ti] <= sub ? sum_reg[ti] - (PW + 4)'(prod_sh)
                                               : sum_reg[ti] + (PW + 4)'(prod_sh);
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_MULWB:
                    for (int i = 0; i < 4; i++)
                    begin
                        ar_reg[i] <= sat(sum_reg[i]);
                        ad_reg[i] <= sat(dsum_reg[i]);
                    end
                ST_SQ:
                begin
                    sq_reg  <= sq_sum;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        // hold the sum of squares at the top of PW bits
                        rem_reg  <= (sq_sum > SQMAX) ? SQMAX : sq_sum;
                        root_reg <= '0;
                        bit_reg  <= ($bits(bit_reg))'(RTW - 1);
                    end
                end
                ST_SQRT:
                begin
                    if (rem_reg >= rtrial)
                    begin
                        rem_reg  <= rem_reg - rtrial;
                        root_reg <= root_reg | (RTW'(1) << bit_reg);
                    end
                    if (bit_reg != '0)
                        bit_reg <= bit_reg - 1'b1;
                    else
                    begin
                        if (root_reg == '0 && rem_reg < SQW'(1))
                            zn_reg <= 1'b1;
                        div_reg  <= root_reg | ((rem_reg >= rtrial) ? RTW'(1) : '0);
                        bit_reg  <= ($bits(bit_reg))'(DW);
                        drem_reg <= '0;
                        quo_reg  <= '0;
                        cnt_reg  <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (bit_reg == ($bits(bit_reg))'(DW))
                        neg_reg <= dsrc[CW-1];
                    if (bit_reg != '0)
                    begin
                        if (dshift >= {1'b0, div_reg})
                        begin
                            drem_reg <= dshift - {1'b0, div_reg};
                            quo_reg  <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= dshift;
                            quo_reg  <= {quo_reg[DW-2:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 1'b1;
                    end
                    else
                    begin
                        if (cnt_reg[2])
                            nd_reg[cnt_reg[1:0]] <= sat(qsig);
                        else
                            nr_reg[cnt_reg[1:0]] <= sat(qsig);
                        drem_reg <= '0;
                        quo_reg  <= '0;
                        bit_reg  <= ($bits(bit_reg))'(DW);
                        cnt_reg  <= (cnt_reg[2:0] == 3'd7) ? 6'd0 : cnt_reg + 6'd1;
                        if (cnt_reg[2:0] == 3'd7)
                            sum_reg[0] <= '0;
                    end
                end
                ST_DOT:
                begin
                    sum_reg[0] <= sum_reg[0] + (PW + 4)'(prod_sh);
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3)
                        d_reg <= sat(sum_reg[0] + (PW + 4)'(prod_sh));
                end
                ST_PROJ:
                begin
                    nd_reg[cnt_reg[1:0]] <= sat((PW + 4)'(nd_reg[cnt_reg[1:0]])
                                                - (PW + 4)'(prod_sh));
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_NORMWB:
                    for (int i = 0; i < 4; i++)
                    begin
                        ar_reg[i] <= nr_reg[i];
                        ad_reg[i] <= nd_reg[i];
                    end
                default: ;
            endcase
            // dual sums for the multiply modes
            if (st_reg == ST_MUL && grp != 2'd0
                && !(grp == 2'd2 && mode_reg == MODE_RMUL))
                dsum_reg[ti] <= sub ? dsum_reg[ti] - (PW + 4)'(prod_sh)
                                    : dsum_reg[ti] + (PW + 4)'(prod_sh);
            else if (st_reg == ST_IDLE)
                for (int i = 0; i < 4; i++) dsum_reg[i] <= '0;
        end
    end
endmodule

// File: dv/tb_dual_quaternion_accumulator.sv
// Testbench: random and directed requests checked against a fixed point dual quaternion predictor.
module tb_dual_quaternion_accumulator;
    timeunit 1ns;
    timeprecision 1ps;
    import dqa_pkg::*;

    localparam int FRAC = 16;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] in_real_w;
        logic signed [31:0] in_real_x;
        logic signed [31:0] in_real_y;
        logic signed [31:0] in_real_z;
        logic signed [31:0] in_dual_w;
        logic signed [31:0] in_dual_x;
        logic signed [31:0] in_dual_y;
        logic signed [31:0] in_dual_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_real_w;
        logic signed [31:0] out_real_x;
        logic signed [31:0] out_real_y;
        logic signed [31:0] out_real_z;
        logic signed [31:0] out_dual_w;
        logic signed [31:0] out_dual_x;
        logic signed [31:0] out_dual_y;
        logic signed [31:0] out_dual_z;
        logic               zero_norm;
    } rsp_t;

    typedef longint quat_t [4];

    class dq_scoreboard;
        quat_t acc_r;
        quat_t acc_d;
        rsp_t  pending_rsp [$];
        int    errors;

        function new();
            acc_r = '{64'sd65536, 0, 0, 0};
            acc_d = '{0, 0, 0, 0};
            errors = 0;
        endfunction

        static function longint clamp(longint v);
            if (v > CMAX) return CMAX;
            if (v < CMIN) return CMIN;
            return v;
        endfunction

        // floor of the fixed point product
        static function longint fxmul(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC;
        endfunction

        static function quat_t hamilton(quat_t a, quat_t b);
            quat_t r;
            r[0] = fxmul(a[0], b[0]) - fxmul(a[1], b[1]) - fxmul(a[2], b[2]) - fxmul(a[3], b[3]);
            r[1] = fxmul(a[0], b[1]) + fxmul(a[1], b[0]) + fxmul(a[2], b[3]) - fxmul(a[3], b[2]);
            r[2] = fxmul(a[0], b[2]) - fxmul(a[1], b[3]) + fxmul(a[2], b[0]) + fxmul(a[3], b[1]);
            r[3] = fxmul(a[0], b[3]) + fxmul(a[1], b[2]) - fxmul(a[2], b[1]) + fxmul(a[3], b[0]);
            return r;
        endfunction

        static function logic [63:0] root64(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > v) bt = bt >> 2;
            while (bt != 0)
            begin
                if (v >= res + bt)
                begin
                    v = v - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                    res = res >> 1;
                bt = bt >> 2;
            end
            return res;
        endfunction

        function bit normalize();
            logic [65:0] sumsq;
            logic [63:0] m;
            longint      n;
            longint      d;
            sumsq = 0;
            for (int i = 0; i < 4; i++)
            begin
                m = (acc_r[i] < 0) ? -acc_r[i] : acc_r[i];
                sumsq = sumsq + m * m;
            end
            // hold the sum of squares at the top of 64 bits
            if (sumsq > 66'h0_FFFF_FFFF_FFFF_FFFF) sumsq = 66'h0_FFFF_FFFF_FFFF_FFFF;
            n = longint'(root64(sumsq[63:0]));
            if (n == 0) return 0;
            for (int i = 0; i < 4; i++)
            begin
                acc_r[i] = clamp((acc_r[i] <<< FRAC) / n);
                acc_d[i] = clamp((acc_d[i] <<< FRAC) / n);
            end
            d = 0;
            for (int i = 0; i < 4; i++) d += fxmul(acc_r[i], acc_d[i]);
            d = clamp(d);
            for (int i = 0; i < 4; i++) acc_d[i] = clamp(acc_d[i] - fxmul(acc_r[i], d));
            return 1;
        endfunction

        function void note_request(req_t r);
            quat_t opr;
            quat_t opd;
            quat_t t1;
            quat_t t2;
            rsp_t  e;
            bit    flag;
            opr = '{r.in_real_w, r.in_real_x, r.in_real_y, r.in_real_z};
            opd = '{r.in_dual_w, r.in_dual_x, r.in_dual_y, r.in_dual_z};
            flag = 0;
            case (r.mode)
                MODE_LOAD:
                begin
                    acc_r = opr;
                    acc_d = opd;
                end
                MODE_DMUL:
                begin
                    t1 = hamilton(acc_r, opd);
                    t2 = hamilton(acc_d, opr);
                    for (int i = 0; i < 4; i++) t2[i] += t1[i];
                    t1 = hamilton(acc_r, opr);
                    for (int i = 0; i < 4; i++)
                    begin
                        acc_r[i] = clamp(t1[i]);
                        acc_d[i] = clamp(t2[i]);
                    end
                end
                MODE_RMUL:
                begin
                    t1 = hamilton(acc_r, opr);
                    t2 = hamilton(acc_d, opr);
                    for (int i = 0; i < 4; i++)
                    begin
                        acc_r[i] = clamp(t1[i]);
                        acc_d[i] = clamp(t2[i]);
                    end
                end
                default: flag = !normalize();
            endcase
            e.out_real_w = 32'(acc_r[0]);
            e.out_real_x = 32'(acc_r[1]);
            e.out_real_y = 32'(acc_r[2]);
            e.out_real_z = 32'(acc_r[3]);
            e.out_dual_w = 32'(acc_d[0]);
            e.out_dual_x = 32'(acc_d[1]);
            e.out_dual_y = 32'(acc_d[2]);
            e.out_dual_z = 32'(acc_d[3]);
            e.zero_norm = flag;
            pending_rsp.push_back(e);
        endfunction

        function void field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_response(rsp_t a);
            rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            field("out_real_w", e.out_real_w, a.out_real_w);
            field("out_real_x", e.out_real_x, a.out_real_x);
            field("out_real_y", e.out_real_y, a.out_real_y);
            field("out_real_z", e.out_real_z, a.out_real_z);
            field("out_dual_w", e.out_dual_w, a.out_dual_w);
            field("out_dual_x", e.out_dual_x, a.out_dual_x);
            field("out_dual_y", e.out_dual_y, a.out_dual_y);
            field("out_dual_z", e.out_dual_z, a.out_dual_z);
            field("zero_norm", e.zero_norm, a.zero_norm);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   long_hold;

    dqa_if #(.payload_t(req_t)) req ();
    dqa_if #(.payload_t(rsp_t)) rsp ();

    dual_quaternion_accumulator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    dq_scoreboard sb = new();

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL dual_quaternion_accumulator");
        $finish;
    end

    always @(posedge clk)
    begin
        if (req.valid && req.ready) sb.note_request(req.data);
        if (rsp.valid && rsp.ready) sb.check_response(rsp.data);
    end

    // receiver: alternate full-rate and random stall stretches, plus one long hold
    initial
    begin
        int seg;
        bit choppy;
        rsp.ready <= 0;
        seg = 0;
        choppy = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                rsp.ready <= 0;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            else
            begin
                if (seg == 0)
                begin
                    seg = $urandom_range(20, 300);
                    choppy = $urandom_range(0, 1);
                end
                seg--;
                rsp.ready <= choppy ? ($urandom_range(0, 3) == 0) : 1'b1;
            end
        end
    end

    function automatic logic [31:0] rand_comp(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 2) == 0 ? 32'sh0001_0000 : 32'sh0000_0000;
            default: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
        endcase
    endfunction

    function automatic req_t rand_request();
        req_t r;
        int   kind;
        kind = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 5) == 0 ? 1 : 2);
        r.mode = mode_t'($urandom_range(0, 3));
        r.in_real_w = rand_comp(kind);
        r.in_real_x = rand_comp(kind);
        r.in_real_y = rand_comp(kind);
        r.in_real_z = rand_comp(kind);
        r.in_dual_w = rand_comp(kind);
        r.in_dual_x = rand_comp(kind);
        r.in_dual_y = rand_comp(kind);
        r.in_dual_z = rand_comp(kind);
        return r;
    endfunction

    function automatic req_t make_request(mode_t m, logic [31:0] rv, logic [31:0] dv);
        req_t r;
        r.mode = m;
        {r.in_real_w, r.in_real_x, r.in_real_y, r.in_real_z} = {4{rv}};
        {r.in_dual_w, r.in_dual_x, r.in_dual_y, r.in_dual_z} = {4{dv}};
        return r;
    endfunction

    task automatic send_request(req_t r);
        req.data <= r;
        req.valid <= 1;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic pause_sender(int cycles);
        req.valid <= 0;
        repeat (cycles) @(posedge clk);
    endtask

    initial
    begin
        req_t r;
        int   burst;
        req.valid <= 0;
        req.data <= '0;
        rst_n <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed: identity state, extremes, zero length, overflowing length
        send_request(make_request(MODE_NORM, 0, 0));
        send_request(make_request(MODE_DMUL, 32'sh0001_0000, 32'sh0000_8000));
        send_request(make_request(MODE_RMUL, 32'sh0000_C000, 0));
        send_request(make_request(MODE_NORM, 0, 0));
        send_request(make_request(MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000));
        send_request(make_request(MODE_DMUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_request(MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_request(MODE_NORM, 0, 0));
        send_request(make_request(MODE_LOAD, 32'h8000_0000, 32'h8000_0000));
        send_request(make_request(MODE_RMUL, 32'h8000_0000, 0));
        send_request(make_request(MODE_LOAD, 0, 32'sh0003_0000));
        send_request(make_request(MODE_NORM, 0, 0));
        send_request(make_request(MODE_DMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(MODE_LOAD, 32'sh0000_0001, 32'sh0000_0001));
        send_request(make_request(MODE_NORM, 0, 0));
        send_request(make_request(MODE_LOAD, 32'sh0002_0000, 32'shFFFF_0000));
        send_request(make_request(MODE_NORM, 0, 0));
        send_request(make_request(MODE_DMUL, 32'sh0000_B505, 32'sh0000_4000));
        send_request(make_request(MODE_RMUL, 32'shFFFF_4AFB, 32'h8000_0000));
        pause_sender(3);

        for (int i = 0; i < 500; )
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && i < 500; j++, i++)
            begin
                if (i == 150) long_hold = 1;
                r = rand_request();
                send_request(r);
            end
            pause_sender($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 60));
        end
        req.valid <= 0;

        while (sb.pending_rsp.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS dual_quaternion_accumulator");
        else
            $display("FAIL dual_quaternion_accumulator");
        $finish;
    end
endmodule

// File: files.f
hdl/dqa_pkg.sv
hdl/dqa_if.sv
hdl/dual_quaternion_accumulator.sv
dv/tb_dual_quaternion_accumulator.sv
